>>> rtl/core/depth_fog_pixel_blend_assert.svh
// assertion macros shared by the fog blend checker
`ifndef DEPTH_FOG_PIXEL_BLEND_ASSERT_SVH
`define DEPTH_FOG_PIXEL_BLEND_ASSERT_SVH

// same-cycle implication, checked outside reset
`define DFOG_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fog blend check failed");

// next-cycle implication, checked outside reset
`define DFOG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fog blend check failed");

// next-cycle implication that also holds across reset
`define DFOG_ASSERT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("fog blend check failed");

`endif

>>> rtl/core/dfog_pkg.sv
// types, constants and table functions of the depth fog blend
package dfog_pkg;

    localparam logic [16:0] ONE = 17'd65536;
    localparam logic [12:0] FALLOFF_MIN = 13'd26;
    localparam logic signed [17:0] SPAN_MIN = 18'sd6;
    localparam logic signed [17:0] SPAN_WIDE = 18'sd66;
    localparam int DIV_STAGES = 16;
    localparam int POW_STAGES = 9;

    typedef enum logic [2:0] {
        CFG_AMOUNT  = 3'd0,
        CFG_START   = 3'd1,
        CFG_END     = 3'd2,
        CFG_FALLOFF = 3'd3,
        CFG_RED     = 3'd4,
        CFG_GREEN   = 3'd5,
        CFG_BLUE    = 3'd6
    } t_cfg_idx;

    // how the power result is formed
    typedef enum logic [1:0] {
        PW_ZERO  = 2'd0,
        PW_ONE   = 2'd1,
        PW_CALC  = 2'd2,
        PW_EXACT = 2'd3
    } t_pw_kind;

    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_pix;

    // log2 of a Q1.30 value in [1,2], result in Q1.16, by repeated squaring
    function automatic logic [16:0] log2_frac(input logic [63:0] x_in);
        logic [63:0] x;
        logic [16:0] r;
        x = x_in;
        r = '0;
        if (x >= 64'h8000_0000) begin
            r = ONE;
        end else begin
            for (int k = 0; k < 16; k++) begin
                x = (x * x) >> 30;
                r = r << 1;
                if (x >= 64'h8000_0000) begin
                    r = r | 17'd1;
                    x = x >> 1;
                end
            end
        end
        return r;
    endfunction

    // largest Q2.16 value whose log2 does not exceed t
    function automatic logic [17:0] exp_search(input logic [16:0] t);
        logic [17:0] lo;
        logic [17:0] hi;
        logic [17:0] mid;
        lo = 18'd65536;
        hi = 18'd131072;
        for (int k = 0; k < 18; k++) begin
            if (lo < hi) begin
                mid = lo + ((hi - lo + 18'd1) >> 1);
                if (log2_frac({32'd0, mid, 14'd0}) <= t) begin
                    lo = mid;
                end else begin
                    hi = mid - 18'd1;
                end
            end
        end
        return lo;
    endfunction

endpackage

>>> rtl/core/dfog_div.sv
// pipelined restoring divider, one quotient bit per stage
module dfog_div (
    input  logic                                  i_clk,
    input  logic [dfog_pkg::DIV_STAGES-1:0]       i_go,
    input  logic [15:0]                           i_num,
    input  logic [15:0]                           i_den,
    input  dfog_pkg::t_pw_kind                    i_kind,
    output logic [15:0]                           o_quo,
    output dfog_pkg::t_pw_kind                    o_kind
);

    logic [15:0]         r_rem  [dfog_pkg::DIV_STAGES];
    logic [15:0]         r_quo  [dfog_pkg::DIV_STAGES];
    logic [15:0]         r_den  [dfog_pkg::DIV_STAGES];
    dfog_pkg::t_pw_kind  r_kind [dfog_pkg::DIV_STAGES];

    for (genvar k = 0; k < dfog_pkg::DIV_STAGES; k++) begin : g_step
        logic [15:0]        w_rem;
        logic [15:0]        w_quo;
        logic [15:0]        w_den;
        dfog_pkg::t_pw_kind w_kind;
        logic [16:0]        w_dbl;
        logic [16:0]        w_sub;

        // operands from the previous stage or the input
        if (k == 0) begin : g_first
            assign w_rem  = i_num;
            assign w_quo  = '0;
            assign w_den  = i_den;
            assign w_kind = i_kind;
        end else begin : g_next
            assign w_rem  = r_rem[k-1];
            assign w_quo  = r_quo[k-1];
            assign w_den  = r_den[k-1];
            assign w_kind = r_kind[k-1];
        end

        assign w_dbl = {w_rem, 1'b0};
        assign w_sub = w_dbl - {1'b0, w_den};

        // trial subtract and shift in one quotient bit
        always_ff @(posedge i_clk) begin
            if (i_go[k]) begin
                if (w_dbl >= {1'b0, w_den}) begin
                    r_rem[k] <= w_sub[15:0];
                    r_quo[k] <= {w_quo[14:0], 1'b1};
                end else begin
                    r_rem[k] <= w_dbl[15:0];
                    r_quo[k] <= {w_quo[14:0], 1'b0};
                end
                r_den[k]  <= w_den;
                r_kind[k] <= w_kind;
            end
        end
    end

    assign o_quo  = r_quo[dfog_pkg::DIV_STAGES-1];
    assign o_kind = r_kind[dfog_pkg::DIV_STAGES-1];

endmodule

>>> rtl/core/dfog_pow.sv
// pipelined fixed point power n^f through log2 and exp2 tables
module dfog_pow #(
    parameter int POW_TABLE_ENTRIES = 256
) (
    input  logic                                  i_clk,
    input  logic [dfog_pkg::POW_STAGES-1:0]       i_go,
    input  logic [15:0]                           i_norm,
    input  dfog_pkg::t_pw_kind                    i_kind,
    input  logic [12:0]                           i_fall,
    output logic [16:0]                           o_pw
);

    localparam int IW  = $clog2(POW_TABLE_ENTRIES + 1);
    localparam int PW1 = 15 + IW;
    localparam int PW2 = 16 + IW;

    logic [16:0] w_log_tab [0:POW_TABLE_ENTRIES];
    logic [17:0] w_exp_tab [0:POW_TABLE_ENTRIES];

    // constant tables worked out at elaboration
    for (genvar gi = 0; gi <= POW_TABLE_ENTRIES; gi++) begin : g_tab
        localparam logic [63:0] LX = 64'(1 << 30) + ((64'(gi) << 30) / POW_TABLE_ENTRIES);
        localparam logic [16:0] LT = 17'((64'(gi) << 16) / POW_TABLE_ENTRIES);
        assign w_log_tab[gi] = dfog_pkg::log2_frac(LX);
        assign w_exp_tab[gi] = dfog_pkg::exp_search(LT);
    end

    logic [IW-1:0]       r1_idx;
    logic [14:0]         r1_rem;
    logic [3:0]          r1_p;
    dfog_pkg::t_pw_kind  r1_kind;
    logic [16:0]         r2_lo;
    logic [16:0]         r2_diff;
    logic [14:0]         r2_rem;
    logic [3:0]          r2_p;
    dfog_pkg::t_pw_kind  r2_kind;
    logic [31:0]         r3_prod;
    logic [16:0]         r3_lo;
    logic [3:0]          r3_p;
    dfog_pkg::t_pw_kind  r3_kind;
    logic [20:0]         r4_qlog;
    dfog_pkg::t_pw_kind  r4_kind;
    logic [25:0]         r5_q;
    dfog_pkg::t_pw_kind  r5_kind;
    logic [IW-1:0]       r6_idx;
    logic [15:0]         r6_rem;
    logic [3:0]          r6_ip;
    dfog_pkg::t_pw_kind  r6_kind;
    logic [17:0]         r7_lo;
    logic [17:0]         r7_diff;
    logic [15:0]         r7_rem;
    logic [3:0]          r7_ip;
    dfog_pkg::t_pw_kind  r7_kind;
    logic [33:0]         r8_prod;
    logic [17:0]         r8_lo;
    logic [3:0]          r8_ip;
    dfog_pkg::t_pw_kind  r8_kind;
    logic [16:0]         r9_pw;

    logic [3:0]          n_p;
    logic [15:0]         w_mant;
    logic [PW1-1:0]      w_pos1;
    logic [IW-1:0]       w_idx1n;
    logic [16:0]         w_lm;
    logic [4:0]          w_exp_int;
    logic [33:0]         w_qprod;
    logic [9:0]          w_ip;
    logic [15:0]         w_fp;
    logic [16:0]         w_omf;
    logic [PW2-1:0]      w_pos2;
    dfog_pkg::t_pw_kind  n_kind6;
    logic [IW-1:0]       w_idx2n;
    logic [17:0]         w_e;
    logic [17:0]         w_esh;
    logic [16:0]         n_pw;

    // leading one, normalise mantissa, locate log table slot
    always_comb begin
        n_p = '0;
        for (int i = 0; i < 16; i++) begin
            if (i_norm[i]) begin
                n_p = 4'(i);
            end
        end
        w_mant = i_norm << (4'd15 - n_p);
        w_pos1 = PW1'(w_mant[14:0]) * PW1'(POW_TABLE_ENTRIES);
    end

    assign w_idx1n = r1_idx + IW'(1);

    // log interpolation sum, integer part and falloff product
    assign w_lm      = r3_lo + r3_prod[31:15];
    assign w_exp_int = 5'd16 - {1'b0, r3_p};
    assign w_qprod   = 34'(r4_qlog) * 34'(i_fall);

    // split exponent, classify result kind, locate exp table slot
    always_comb begin
        w_ip    = r5_q[25:16];
        w_fp    = r5_q[15:0];
        w_omf   = dfog_pkg::ONE - {1'b0, w_fp};
        w_pos2  = PW2'(w_omf[15:0]) * PW2'(POW_TABLE_ENTRIES);
        n_kind6 = r5_kind;
        if (r5_kind == dfog_pkg::PW_CALC) begin
            if (w_ip >= 10'd16) begin
                n_kind6 = dfog_pkg::PW_ZERO;
            end else if (w_fp == 16'd0) begin
                n_kind6 = dfog_pkg::PW_EXACT;
            end
        end
    end

    assign w_idx2n = r6_idx + IW'(1);

    // exp interpolation and final shift, with special-case results
    always_comb begin
        w_e   = r8_lo + r8_prod[33:16];
        w_esh = w_e >> ({1'b0, r8_ip} + 5'd1);
        case (r8_kind)
            dfog_pkg::PW_ZERO:  n_pw = '0;
            dfog_pkg::PW_ONE:   n_pw = dfog_pkg::ONE;
            dfog_pkg::PW_EXACT: n_pw = dfog_pkg::ONE >> r8_ip;
            default:            n_pw = w_esh[16:0];
        endcase
    end

    // stage registers
    always_ff @(posedge i_clk) begin
        if (i_go[0]) begin
            r1_idx  <= w_pos1[PW1-1:15];
            r1_rem  <= w_pos1[14:0];
            r1_p    <= n_p;
            r1_kind <= i_kind;
        end
        if (i_go[1]) begin
            r2_lo   <= w_log_tab[r1_idx];
            r2_diff <= w_log_tab[w_idx1n] - w_log_tab[r1_idx];
            r2_rem  <= r1_rem;
            r2_p    <= r1_p;
            r2_kind <= r1_kind;
        end
        if (i_go[2]) begin
            r3_prod <= 32'(r2_diff) * 32'(r2_rem);
            r3_lo   <= r2_lo;
            r3_p    <= r2_p;
            r3_kind <= r2_kind;
        end
        if (i_go[3]) begin
            r4_qlog <= {w_exp_int, 16'd0} - 21'(w_lm);
            r4_kind <= r3_kind;
        end
        if (i_go[4]) begin
            r5_q    <= w_qprod[33:8];
            r5_kind <= r4_kind;
        end
        if (i_go[5]) begin
            r6_idx  <= w_pos2[PW2-1:16];
            r6_rem  <= w_pos2[15:0];
            r6_ip   <= w_ip[3:0];
            r6_kind <= n_kind6;
        end
        if (i_go[6]) begin
            r7_lo   <= w_exp_tab[r6_idx];
            r7_diff <= w_exp_tab[w_idx2n] - w_exp_tab[r6_idx];
            r7_rem  <= r6_rem;
            r7_ip   <= r6_ip;
            r7_kind <= r6_kind;
        end
        if (i_go[7]) begin
            r8_prod <= 34'(r7_diff) * 34'(r7_rem);
            r8_lo   <= r7_lo;
            r8_ip   <= r7_ip;
            r8_kind <= r7_kind;
        end
        if (i_go[8]) begin
            r9_pw <= n_pw;
        end
    end

    assign o_pw = r9_pw;

endmodule

>>> rtl/core/depth_fog_pixel_blend.sv
// depth fog blend: each input beat passes through a chain of stage registers to the output beat
// throughput one pixel per clock while m_tready holds; each stage holds while the next is full and stalled
// the pipe includes the 16-stage divider and the 9-stage power unit, all fully pipelined
// reset clears every stage valid bit and loads the fog registers with their defaults
// the configuration port is always ready; writes to unknown indices are dropped
module depth_fog_pixel_blend #(
    parameter int POW_TABLE_ENTRIES = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // depth_value, in_red, in_green, in_blue, in_alpha
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // out_red, out_green, out_blue, out_alpha
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [16:0] i_cfg_data
);

    localparam int ST_DIV = 1;
    localparam int ST_POW = ST_DIV + dfog_pkg::DIV_STAGES;
    localparam int ST_FAC = ST_POW + dfog_pkg::POW_STAGES;
    localparam int ST_OUT = ST_FAC + 1;
    localparam int NS     = ST_OUT + 1;

    logic [16:0] r_amount;
    logic [15:0] r_start;
    logic [15:0] r_end;
    logic [12:0] r_falloff;
    logic [7:0]  r_fog_red;
    logic [7:0]  r_fog_green;
    logic [7:0]  r_fog_blue;

    logic [NS-1:0]   r_vld;
    logic [NS:0]     w_go;
    dfog_pkg::t_pix  r_pix [NS-1];

    logic [15:0]         r_num;
    logic [15:0]         r_den;
    dfog_pkg::t_pw_kind  r_kind;
    logic [15:0]         w_quo;
    dfog_pkg::t_pw_kind  w_div_kind;
    logic [16:0]         w_pw;
    logic [16:0]         r_fac;
    logic [31:0]         r_out;

    logic [16:0]         w_dist;
    logic signed [17:0]  w_span;
    logic signed [17:0]  w_numer;
    logic signed [17:0]  w_n;
    logic signed [17:0]  w_s;
    dfog_pkg::t_pw_kind  n_kind;
    logic [12:0]         w_fall;
    logic [16:0]         w_amt;
    logic [33:0]         w_fac_prod;
    logic [16:0]         w_inv;
    logic [24:0]         w_mix_r;
    logic [24:0]         w_mix_g;
    logic [24:0]         w_mix_b;

    // configuration writes
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amount    <= '0;
            r_start     <= '0;
            r_end       <= 16'hFFFF;
            r_falloff   <= 13'd256;
            r_fog_red   <= 8'hFF;
            r_fog_green <= 8'hFF;
            r_fog_blue  <= 8'hFF;
        end else if (i_cfg_valid) begin
            unique case (dfog_pkg::t_cfg_idx'(i_cfg_index))
                dfog_pkg::CFG_AMOUNT:  r_amount    <= i_cfg_data;
                dfog_pkg::CFG_START:   r_start     <= i_cfg_data[15:0];
                dfog_pkg::CFG_END:     r_end       <= i_cfg_data[15:0];
                dfog_pkg::CFG_FALLOFF: r_falloff   <= i_cfg_data[12:0];
                dfog_pkg::CFG_RED:     r_fog_red   <= i_cfg_data[7:0];
                dfog_pkg::CFG_GREEN:   r_fog_green <= i_cfg_data[7:0];
                dfog_pkg::CFG_BLUE:    r_fog_blue  <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // stage advance chain, a stage moves when empty or when the next one moves
    always_comb begin
        w_go[NS] = m_tready;
        for (int k = NS - 1; k >= 0; k--) begin
            w_go[k] = !r_vld[k] || w_go[k+1];
        end
    end

    assign s_tready = w_go[0];
    assign m_tvalid = r_vld[NS-1];
    assign m_tdata  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NS; k++) begin
                if (w_go[k]) begin
                    r_vld[k] <= (k == 0) ? s_tvalid : r_vld[k-1];
                end
            end
        end
    end

    // pixel bytes ride alongside the arithmetic
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NS - 1; k++) begin
            if (w_go[k]) begin
                r_pix[k] <= (k == 0) ? dfog_pkg::t_pix'(s_tdata[47:16]) : r_pix[k-1];
            end
        end
    end

    // distance, span and sign handling ahead of the divider
    always_comb begin
        w_dist  = dfog_pkg::ONE - {1'b0, s_tdata[15:0]};
        w_span  = $signed({2'b00, r_end}) - $signed({2'b00, r_start});
        if (w_span >= -dfog_pkg::SPAN_MIN && w_span <= dfog_pkg::SPAN_MIN) begin
            w_span = dfog_pkg::SPAN_WIDE;
        end
        w_numer = $signed({1'b0, w_dist}) - $signed({2'b00, r_start});
        if (w_span > 18'sd0) begin
            w_n = w_numer;
            w_s = w_span;
        end else begin
            w_n = -w_numer;
            w_s = -w_span;
        end
        if (w_n <= 18'sd0) begin
            n_kind = dfog_pkg::PW_ZERO;
        end else if (w_n >= w_s) begin
            n_kind = dfog_pkg::PW_ONE;
        end else begin
            n_kind = dfog_pkg::PW_CALC;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go[0]) begin
            r_num  <= w_n[15:0];
            r_den  <= w_s[15:0];
            r_kind <= n_kind;
        end
    end

    dfog_div u_div (
        .i_clk  (i_clk),
        .i_go   (w_go[ST_DIV +: dfog_pkg::DIV_STAGES]),
        .i_num  (r_num),
        .i_den  (r_den),
        .i_kind (r_kind),
        .o_quo  (w_quo),
        .o_kind (w_div_kind)
    );

    assign w_fall = (r_falloff < dfog_pkg::FALLOFF_MIN) ? dfog_pkg::FALLOFF_MIN : r_falloff;

    dfog_pow #(
        .POW_TABLE_ENTRIES (POW_TABLE_ENTRIES)
    ) u_pow (
        .i_clk  (i_clk),
        .i_go   (w_go[ST_POW +: dfog_pkg::POW_STAGES]),
        .i_norm (w_quo),
        .i_kind (w_div_kind),
        .i_fall (w_fall),
        .o_pw   (w_pw)
    );

    // amount scaling
    assign w_amt      = (r_amount > dfog_pkg::ONE) ? dfog_pkg::ONE : r_amount;
    assign w_fac_prod = 34'(w_amt) * 34'(w_pw);

    always_ff @(posedge i_clk) begin
        if (w_go[ST_FAC]) begin
            r_fac <= w_fac_prod[32:16];
        end
    end

    // colour blend toward fog, truncated
    assign w_inv   = dfog_pkg::ONE - r_fac;
    assign w_mix_r = 25'(r_pix[ST_FAC].red) * 25'(w_inv) + 25'(r_fog_red) * 25'(r_fac);
    assign w_mix_g = 25'(r_pix[ST_FAC].green) * 25'(w_inv) + 25'(r_fog_green) * 25'(r_fac);
    assign w_mix_b = 25'(r_pix[ST_FAC].blue) * 25'(w_inv) + 25'(r_fog_blue) * 25'(r_fac);

    always_ff @(posedge i_clk) begin
        if (w_go[ST_OUT]) begin
            r_out <= {r_pix[ST_FAC].alpha, w_mix_b[23:16], w_mix_g[23:16], w_mix_r[23:16]};
        end
    end

endmodule

>>> rtl/core/dfog_chk.sv
// port checker for the depth fog blend, bound to the top level
`include "depth_fog_pixel_blend_assert.svh"

module dfog_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    // a stalled output beat holds its value
    `DFOG_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // an empty output stage leaves the whole pipe free to take a beat
    `DFOG_ASSERT_NOW(a_empty_ready, i_clk, i_rst_n, !m_tvalid, s_tready)

    // a draining sink never back-pressures the source
    `DFOG_ASSERT_NOW(a_sink_ready, i_clk, i_rst_n, m_tready, s_tready)

    // reset empties the pipe
    `DFOG_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n, !m_tvalid)

endmodule

bind depth_fog_pixel_blend dfog_chk u_dfog_chk (.*);
